// ===== rtl/tcw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer package
// Geometry, field widths, codes and the controller/datapath link types.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int COLUMNS     = 80;
  localparam int ROWS        = 25;
  localparam int CELLS       = ROWS * COLUMNS;
  localparam int ROW_W       = $clog2(ROWS);
  localparam int COL_W       = $clog2(COLUMNS);
  localparam int CELL_W      = $clog2(CELLS);
  localparam int IDX_W       = 11;
  localparam int DATA_W      = 16;
  localparam int ATTR_W      = 8;
  localparam int CHAR_W      = 8;
  localparam int SCROLL_LAST = COLUMNS * (ROWS - 1) - 1;
  localparam int FILL_LAST   = CELLS - 1;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
  localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;
  localparam logic [ATTR_W-1:0] TEXT_ATTR_RST  = 8'h0F;
  localparam logic [ATTR_W-1:0] BLANK_ATTR_RST = 8'h07;

  typedef enum logic [1:0] {
    KIND_PUT   = 2'd0,
    KIND_CLEAR = 2'd1,
    KIND_READ  = 2'd2
  } kind_e;

  typedef enum logic {
    CFG_TEXT_ATTR  = 1'b0,
    CFG_BLANK_ATTR = 1'b1
  } cfg_idx_e;

  typedef enum logic [5:0] {
    ST_INIT   = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_SCROLL = 6'b000100,
    ST_DRAIN  = 6'b001000,
    ST_FILL   = 6'b010000,
    ST_DONE   = 6'b100000
  } state_e;

  typedef struct packed {
    logic accept;
    logic put_step;
    logic clear_start;
    logic scroll_rd;
    logic fill;
    logic fill_zero;
    logic out_load;
  } tcw_cmd_t;

  typedef struct packed {
    logic put_scroll;
    logic ptr_scroll_last;
    logic ptr_fill_last;
    logic out_free;
  } tcw_sts_t;

endpackage

// ===== rtl/tcw_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer controller
// Sequences request acceptance, scroll copy, blank fill and result hand-off.
// ----------------------------------------------------------------------------
module tcw_ctrl import tcw_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic [1:0]  in_kind_i,
  output logic        in_stall_o,
  input  tcw_sts_t    sts_i,
  output tcw_cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_INIT: begin
        cmd_o.fill      = 1'b1;
        cmd_o.fill_zero = 1'b1;
        if (sts_i.ptr_fill_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          priority if (in_kind_i == KIND_PUT) begin
            cmd_o.put_step = 1'b1;
            state_d = sts_i.put_scroll ? ST_SCROLL : ST_DONE;
          end else if (in_kind_i == KIND_CLEAR) begin
            cmd_o.clear_start = 1'b1;
            state_d = ST_FILL;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_SCROLL: begin
        cmd_o.scroll_rd = 1'b1;
        if (sts_i.ptr_scroll_last) state_d = ST_DRAIN;
      end
      // last copy write lands here
      ST_DRAIN: state_d = ST_FILL;
      ST_FILL: begin
        cmd_o.fill = 1'b1;
        if (sts_i.ptr_fill_last) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_INIT;
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/tcw_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer datapath
// Screen memory, cursor, attribute registers, sweep pointer and result register.
// ----------------------------------------------------------------------------
module tcw_datapath import tcw_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tcw_cmd_t          cmd_i,
  output tcw_sts_t          sts_o,
  input  logic [1:0]        in_kind_i,
  input  logic [CHAR_W-1:0] in_char_code_i,
  input  logic [IDX_W-1:0]  in_cell_index_i,
  input  logic              cfg_we_i,
  input  logic              cfg_index_i,
  input  logic [ATTR_W-1:0] cfg_data_i,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output logic [DATA_W-1:0] out_cell_data_o,
  output logic [ROW_W-1:0]  out_cursor_row_out_o,
  output logic [COL_W-1:0]  out_cursor_col_out_o
);

  logic [DATA_W-1:0] mem_q [CELLS];
  logic [DATA_W-1:0] rdata_q;

  logic [ATTR_W-1:0] text_attr_q, blank_attr_q;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [CELL_W-1:0] ptr_q, ptr_d;
  logic [CELL_W-1:0] cpy_addr_q, cpy_addr_d;
  logic              cpy_pend_q, cpy_pend_d;
  logic              read_hit_q, read_hit_d;

  logic              out_valid_q;
  logic [DATA_W-1:0] out_cell_q;
  logic [ROW_W-1:0]  out_row_q;
  logic [COL_W-1:0]  out_col_q;

  logic [CELL_W-1:0] pos;
  logic              is_newline, col_last, row_last, next_row, idx_ok;
  logic              we, re;
  logic [CELL_W-1:0] waddr, raddr;
  logic [DATA_W-1:0] wdata;

  assign pos        = CELL_W'(row_q) * CELL_W'(COLUMNS) + CELL_W'(col_q);
  assign is_newline = (in_char_code_i == NEWLINE_CODE);
  assign col_last   = (col_q == COL_W'(COLUMNS - 1));
  assign row_last   = (row_q == ROW_W'(ROWS - 1));
  assign next_row   = is_newline || col_last;
  assign idx_ok     = (int'(in_cell_index_i) < CELLS);

  assign sts_o.put_scroll      = next_row && row_last;
  assign sts_o.ptr_scroll_last = (ptr_q == CELL_W'(SCROLL_LAST));
  assign sts_o.ptr_fill_last   = (ptr_q == CELL_W'(FILL_LAST));
  assign sts_o.out_free        = !out_valid_q || !out_stall_i;

  // write port: pending copy, put, then fill; never more than one at a time
  always_comb begin
    we    = 1'b0;
    waddr = ptr_q;
    wdata = '0;
    priority if (cpy_pend_q) begin
      we    = 1'b1;
      waddr = cpy_addr_q;
      wdata = rdata_q;
    end else if (cmd_i.put_step && !is_newline) begin
      we    = 1'b1;
      waddr = pos;
      wdata = {text_attr_q, in_char_code_i};
    end else if (cmd_i.fill) begin
      we    = 1'b1;
      waddr = ptr_q;
      wdata = cmd_i.fill_zero ? '0 : {blank_attr_q, SPACE_CODE};
    end else begin
      we    = 1'b0;
    end
  end

  assign re    = cmd_i.scroll_rd ||
                 (cmd_i.accept && (in_kind_i == KIND_READ) && idx_ok);
  assign raddr = cmd_i.scroll_rd ? ptr_q + CELL_W'(COLUMNS) : CELL_W'(in_cell_index_i);

  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    if (re) rdata_q <= mem_q[raddr];
  end

  always_comb begin
    row_d      = row_q;
    col_d      = col_q;
    ptr_d      = ptr_q;
    cpy_addr_d = cpy_addr_q;
    cpy_pend_d = 1'b0;
    read_hit_d = read_hit_q;
    if (cmd_i.accept) read_hit_d = (in_kind_i == KIND_READ) && idx_ok;
    if (cmd_i.put_step) begin
      if (next_row) begin
        col_d = '0;
        if (row_last) ptr_d = '0;
        else          row_d = row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
    if (cmd_i.clear_start) begin
      row_d = '0;
      col_d = '0;
      ptr_d = '0;
    end
    if (cmd_i.scroll_rd) begin
      cpy_addr_d = ptr_q;
      cpy_pend_d = 1'b1;
      ptr_d      = ptr_q + 1'b1;
    end
    if (cmd_i.fill) ptr_d = ptr_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_attr_q  <= TEXT_ATTR_RST;
      blank_attr_q <= BLANK_ATTR_RST;
      row_q        <= '0;
      col_q        <= '0;
      ptr_q        <= '0;
      cpy_pend_q   <= 1'b0;
      read_hit_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_TEXT_ATTR:  text_attr_q  <= cfg_data_i;
          CFG_BLANK_ATTR: blank_attr_q <= cfg_data_i;
          default: ;
        endcase
      end
      row_q      <= row_d;
      col_q      <= col_d;
      ptr_q      <= ptr_d;
      cpy_pend_q <= cpy_pend_d;
      read_hit_q <= read_hit_d;
      if (cmd_i.out_load)  out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    cpy_addr_q <= cpy_addr_d;
    if (cmd_i.out_load) begin
      out_cell_q <= read_hit_q ? rdata_q : '0;
      out_row_q  <= row_q;
      out_col_q  <= col_q;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign out_cell_data_o      = out_cell_q;
  assign out_cursor_row_out_o = out_row_q;
  assign out_cursor_col_out_o = out_col_q;

endmodule

// ===== rtl/text_console_writer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer core
// 80x25 text screen with cursor: put, clear and cell read requests.
// ----------------------------------------------------------------------------
// After reset the block zeroes its screen memory, one cell per cycle, with
// in_stall_o high; configuration writes are always taken. A put, a read or
// an unused kind is accepted in ST_IDLE; a put's write and cursor update or a
// read's memory access happen on that edge, and the result register is loaded
// in ST_DONE once it is free. A put past the last row adds a scroll copy of
// 1920 cells (one memory read and one write per cycle), a drain state and a
// blank fill of the last row's 80 cells; a clear blank-fills all 2000 cells.
// The result register lets the next request be accepted while a result waits.
module text_console_writer_core import tcw_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        in_kind_i,
  input  logic [CHAR_W-1:0] in_char_code_i,
  input  logic [IDX_W-1:0]  in_cell_index_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [DATA_W-1:0] out_cell_data_o,
  output logic [ROW_W-1:0]  out_cursor_row_out_o,
  output logic [COL_W-1:0]  out_cursor_col_out_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic              cfg_index_i,
  input  logic [ATTR_W-1:0] cfg_data_i
);

  tcw_cmd_t cmd;
  tcw_sts_t sts;

  assign cfg_ready_o = 1'b1;

  tcw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_kind_i  (in_kind_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tcw_datapath u_datapath (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .sts_o                (sts),
    .in_kind_i            (in_kind_i),
    .in_char_code_i       (in_char_code_i),
    .in_cell_index_i      (in_cell_index_i),
    .cfg_we_i             (cfg_valid_i && cfg_ready_o),
    .cfg_index_i          (cfg_index_i),
    .cfg_data_i           (cfg_data_i),
    .out_stall_i          (out_stall_i),
    .out_valid_o          (out_valid_o),
    .out_cell_data_o      (out_cell_data_o),
    .out_cursor_row_out_o (out_cursor_row_out_o),
    .out_cursor_col_out_o (out_cursor_col_out_o)
  );

endmodule
